// File: src/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg
// Shared types and constants for the 6502 execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cie_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int IN_W        = 64;
    localparam int OUT_W       = 88;

    localparam logic [15:0] BREAK_RESET = 16'hFFFE;
    localparam logic [15:0] START_RESET = 16'h0000;
    localparam logic [7:0]  SP_RESET    = 8'hFD;
    localparam logic [7:0]  P_RESET     = 8'h24;
    localparam logic [7:0]  STACK_PAGE  = 8'h01;

    localparam int FC = 0;
    localparam int FZ = 1;
    localparam int FI = 2;
    localparam int FD = 3;
    localparam int FB = 4;
    localparam int FU = 5;
    localparam int FV = 6;
    localparam int FN = 7;

    localparam logic CFG_BREAK_TARGET = 1'b0;
    localparam logic CFG_START_PC     = 1'b1;

    typedef enum logic [5:0] {
        OP_XXX, OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BMI,
        OP_BNE, OP_BPL, OP_BVC, OP_BVS, OP_BIT, OP_BRK, OP_CLC, OP_CLD,
        OP_CLI, OP_CLV, OP_NOP, OP_PHA, OP_PLA, OP_PHP, OP_PLP, OP_RTI,
        OP_RTS, OP_SEC, OP_SED, OP_SEI, OP_TAX, OP_TXA, OP_TAY, OP_TYA,
        OP_TSX, OP_TXS, OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY,
        OP_INX, OP_INY, OP_EOR, OP_INC, OP_JMP, OP_JSR, OP_LDA, OP_LDX,
        OP_LDY, OP_LSR, OP_ORA, OP_ROL, OP_ROR, OP_SBC, OP_STA, OP_STX,
        OP_STY
    } t_func;

    // decoded instruction as it sits in the queue
    typedef struct packed {
        logic [5:0]  func;
        logic        accm;
        logic [7:0]  operand;
        logic [15:0] ea;
        logic [1:0]  len;
        logic [2:0]  base_cyc;
        logic [2:0]  taken_cyc;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  s3;
        logic [1:0]  nwr;       // memory/stack writes when running
        logic        branch;
    } t_item;

endpackage
`default_nettype wire

// File: src/cie_front.sv
// ----------------------------------------------------------------------------
// cie_front
// Accepts instruction transactions and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module cie_front (
    input  wire logic [cie_pkg::IN_W-1:0] i_tdata,
    output cie_pkg::t_item                o_item
);
    import cie_pkg::*;

    logic [5:0] w_func;

    assign w_func = i_tdata[5:0];

    always_comb begin
        o_item           = '0;
        o_item.func      = w_func;
        o_item.accm      = i_tdata[6];
        o_item.operand   = i_tdata[14:7];
        o_item.ea        = i_tdata[30:15];
        o_item.len       = i_tdata[32:31];
        o_item.base_cyc  = i_tdata[35:33];
        o_item.taken_cyc = i_tdata[38:36];
        o_item.s1        = i_tdata[46:39];
        o_item.s2        = i_tdata[54:47];
        o_item.s3        = i_tdata[62:55];
        case (w_func)
            OP_BRK: o_item.nwr = 2'd3;
            OP_JSR: o_item.nwr = 2'd2;
            OP_PHA, OP_PHP, OP_DEC, OP_INC, OP_STA, OP_STX, OP_STY: o_item.nwr = 2'd1;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: o_item.nwr = {1'b0, ~i_tdata[6]};
            default: o_item.nwr = 2'd0;
        endcase
        case (w_func)
            OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS:
                o_item.branch = 1'b1;
            default: o_item.branch = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// File: src/cie_fifo.sv
// ----------------------------------------------------------------------------
// cie_fifo
// Short queue of decoded instructions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module cie_fifo #(
    parameter int DEPTH = cie_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cie_pkg::t_item      i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output cie_pkg::t_item      o_item
);
    import cie_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count lost a push");
    a_pop_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count lost a pop");

endmodule
`default_nettype wire

// File: src/cie_back.sv
// ----------------------------------------------------------------------------
// cie_back
// Register file and ALU; executes one instruction and emits its results.
// ----------------------------------------------------------------------------
`default_nettype none
module cie_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [15:0]               i_cfg_wdata,
    input  wire logic                      i_empty,
    input  cie_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    output logic [cie_pkg::OUT_W-1:0]      o_tdata,
    output logic                           o_tlast
);
    import cie_pkg::*;

    logic [15:0] r_brk, r_pc, n_pc;
    logic [7:0]  r_a, r_x, r_y, r_sp, r_p, n_a, n_x, n_y, n_sp, n_p;
    logic        r_run, n_run;
    logic        r_busy;
    logic [1:0]  r_cnt, r_idx, n_cnt;
    logic [2:0]  r_wait, n_wait;
    logic [15:0] r_wa [3];
    logic [7:0]  r_wd [3];
    logic [15:0] n_wa [3];
    logic [7:0]  n_wd [3];
    logic        w_last, w_fire, w_take, w_we, w_cond;
    logic [8:0]  w_sum;
    logic [7:0]  w_addend, w_cmp_reg, w_diff, w_v, w_r;
    logic [15:0] w_ret;
    logic [1:0]  w_n;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        set_nz = p;
        set_nz[FZ] = (v == 8'h00);
        set_nz[FN] = v[7];
    endfunction

    assign w_n    = (r_cnt == 2'd0) ? 2'd1 : r_cnt;
    assign w_last = (r_idx == w_n - 2'd1);
    assign w_fire = o_tvalid && i_tready;
    assign w_take = !i_empty && (!r_busy || (w_fire && w_last));
    assign o_pop  = w_take;
    assign o_tvalid = r_busy;
    assign o_tlast  = w_last;
    assign w_we     = (r_idx < r_cnt);

    always_comb begin
        o_tdata        = '0;
        o_tdata[0]     = w_we;
        o_tdata[16:1]  = w_we ? r_wa[r_idx] : 16'h0000;
        o_tdata[24:17] = w_we ? r_wd[r_idx] : 8'h00;
        if (w_last) begin
            o_tdata[40:25] = r_pc;
            o_tdata[48:41] = r_p;
            o_tdata[56:49] = r_a;
            o_tdata[64:57] = r_x;
            o_tdata[72:65] = r_y;
            o_tdata[80:73] = r_sp;
            o_tdata[83:81] = r_wait;
            o_tdata[84]    = !r_run;
        end
    end

    // execute
    always_comb begin
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p; n_run = r_run;
        n_wait = i_item.base_cyc;
        n_pc   = r_pc + {14'd0, i_item.len};
        n_cnt  = i_item.nwr;
        w_addend  = (i_item.func == OP_SBC) ? ~i_item.operand : i_item.operand;
        w_sum     = {1'b0, r_a} + {1'b0, w_addend} + {8'd0, r_p[FC]};
        case (i_item.func)
            OP_CPX:  w_cmp_reg = r_x;
            OP_CPY:  w_cmp_reg = r_y;
            default: w_cmp_reg = r_a;
        endcase
        w_diff = w_cmp_reg - i_item.operand;
        w_v    = i_item.accm ? r_a : i_item.operand;
        w_r    = 8'h00;
        w_ret  = (i_item.func == OP_BRK) ? r_pc + 16'd2 : r_pc + {14'd0, i_item.len} - 16'd1;
        n_wa[0] = {STACK_PAGE, r_sp};
        n_wa[1] = {STACK_PAGE, r_sp - 8'd1};
        n_wa[2] = {STACK_PAGE, r_sp - 8'd2};
        n_wd[0] = w_ret[15:8];
        n_wd[1] = w_ret[7:0];
        n_wd[2] = r_p | 8'h30;
        case (i_item.func)
            OP_BCC:  w_cond = !r_p[FC];
            OP_BCS:  w_cond = r_p[FC];
            OP_BEQ:  w_cond = r_p[FZ];
            OP_BMI:  w_cond = r_p[FN];
            OP_BNE:  w_cond = !r_p[FZ];
            OP_BPL:  w_cond = !r_p[FN];
            OP_BVC:  w_cond = !r_p[FV];
            default: w_cond = r_p[FV];
        endcase
        if (!r_run) begin
            n_wait = 3'd0;
            n_pc   = r_pc;
            n_cnt  = 2'd0;
        end else begin
            case (i_item.func)
                OP_XXX: n_run = 1'b0;
                OP_ADC, OP_SBC: begin
                    n_a = w_sum[7:0];
                    n_p = set_nz(r_p, w_sum[7:0]);
                    n_p[FC] = w_sum[8];
                    n_p[FV] = ~(r_a[7] ^ w_addend[7]) & (r_a[7] ^ w_sum[7]);
                end
                OP_AND: begin n_a = r_a & i_item.operand; n_p = set_nz(r_p, n_a); end
                OP_EOR: begin n_a = r_a ^ i_item.operand; n_p = set_nz(r_p, n_a); end
                OP_ORA: begin n_a = r_a | i_item.operand; n_p = set_nz(r_p, n_a); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    case (i_item.func)
                        OP_ASL:  w_r = {w_v[6:0], 1'b0};
                        OP_LSR:  w_r = {1'b0, w_v[7:1]};
                        OP_ROL:  w_r = {w_v[6:0], r_p[FC]};
                        default: w_r = {r_p[FC], w_v[7:1]};
                    endcase
                    n_p = set_nz(r_p, w_r);
                    n_p[FC] = (i_item.func == OP_ASL || i_item.func == OP_ROL) ? w_v[7] : w_v[0];
                    if (i_item.accm) n_a = w_r;
                    n_wa[0] = i_item.ea;
                    n_wd[0] = w_r;
                end
                OP_BIT: begin
                    n_p[FZ] = ((i_item.operand & r_a) == 8'h00);
                    n_p[FV] = i_item.operand[6];
                    n_p[FN] = i_item.operand[7];
                end
                OP_BRK: begin
                    n_sp = r_sp - 8'd3;
                    n_p  = r_p | 8'h14;
                    n_pc = r_brk;
                end
                OP_CLC: n_p[FC] = 1'b0;
                OP_CLD: n_p[FD] = 1'b0;
                OP_CLI: n_p[FI] = 1'b0;
                OP_CLV: n_p[FV] = 1'b0;
                OP_SEC: n_p[FC] = 1'b1;
                OP_SED: n_p[FD] = 1'b1;
                OP_SEI: n_p[FI] = 1'b1;
                OP_PHA: begin n_sp = r_sp - 8'd1; n_wd[0] = r_a; end
                OP_PHP: begin n_sp = r_sp - 8'd1; n_wd[0] = r_p | 8'h10; end
                OP_PLA: begin
                    n_sp = r_sp + 8'd1; n_a = i_item.s1; n_p = set_nz(r_p, i_item.s1);
                end
                OP_PLP: begin n_sp = r_sp + 8'd1; n_p = (i_item.s1 & 8'hEF) | 8'h20; end
                OP_RTI: begin
                    n_sp = r_sp + 8'd3;
                    n_p  = (i_item.s1 & 8'hEF) | 8'h20;
                    n_pc = {i_item.s3, i_item.s2};
                end
                OP_RTS: begin
                    n_sp = r_sp + 8'd2;
                    n_pc = {i_item.s2, i_item.s1} + 16'd1;
                end
                OP_TAX: begin n_x = r_a; n_p = set_nz(r_p, r_a); end
                OP_TXA: begin n_a = r_x; n_p = set_nz(r_p, r_x); end
                OP_TAY: begin n_y = r_a; n_p = set_nz(r_p, r_a); end
                OP_TYA: begin n_a = r_y; n_p = set_nz(r_p, r_y); end
                OP_TSX: begin n_x = r_sp; n_p = set_nz(r_p, r_sp); end
                OP_TXS: n_sp = r_x;
                OP_CMP, OP_CPX, OP_CPY: begin
                    n_p = set_nz(r_p, w_diff);
                    n_p[FC] = (w_cmp_reg >= i_item.operand);
                end
                OP_DEC, OP_INC: begin
                    w_r = (i_item.func == OP_DEC) ? i_item.operand - 8'd1
                                                  : i_item.operand + 8'd1;
                    n_p = set_nz(r_p, w_r);
                    n_wa[0] = i_item.ea;
                    n_wd[0] = w_r;
                end
                OP_DEX: begin n_x = r_x - 8'd1; n_p = set_nz(r_p, n_x); end
                OP_DEY: begin n_y = r_y - 8'd1; n_p = set_nz(r_p, n_y); end
                OP_INX: begin n_x = r_x + 8'd1; n_p = set_nz(r_p, n_x); end
                OP_INY: begin n_y = r_y + 8'd1; n_p = set_nz(r_p, n_y); end
                OP_JMP: n_pc = i_item.ea;
                OP_JSR: begin n_sp = r_sp - 8'd2; n_pc = i_item.ea; end
                OP_LDA: begin n_a = i_item.operand; n_p = set_nz(r_p, n_a); end
                OP_LDX: begin n_x = i_item.operand; n_p = set_nz(r_p, n_x); end
                OP_LDY: begin n_y = i_item.operand; n_p = set_nz(r_p, n_y); end
                OP_STA: begin n_wa[0] = i_item.ea; n_wd[0] = r_a; end
                OP_STX: begin n_wa[0] = i_item.ea; n_wd[0] = r_x; end
                OP_STY: begin n_wa[0] = i_item.ea; n_wd[0] = r_y; end
                default: ;
            endcase
            if (i_item.branch && w_cond) begin
                n_pc   = i_item.ea;
                n_wait = i_item.taken_cyc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk  <= BREAK_RESET;
            r_pc   <= START_RESET;
            r_a    <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_sp   <= SP_RESET;
            r_p    <= P_RESET;
            r_run  <= 1'b1;
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_wait <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BREAK_TARGET) r_brk <= i_cfg_wdata;
                else r_pc <= i_cfg_wdata;
            end
            if (w_take) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp;
                r_p <= n_p; r_pc <= n_pc; r_run <= n_run;
                r_wait <= n_wait;
                r_cnt  <= n_cnt;
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (w_fire) begin
                if (w_last) r_busy <= 1'b0;
                else r_idx <= r_idx + 2'd1;
            end
        end
        if (w_take) begin
            r_wa <= n_wa;
            r_wd <= n_wd;
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |=> !r_run) else $error("halt released without reset");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < w_n) else $error("result index past count");
    a_take_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(w_fire && w_last)) |-> !w_take)
        else $error("new instruction taken over pending results");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> o_tvalid && $stable(r_idx))
        else $error("stalled result dropped");

endmodule
`default_nettype wire

// File: src/cpu6502_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_instruction_execute_unit
// 6502 execute unit: decode front, instruction queue, execute back.
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata low bit up)
// s_axis    in   func, accumulator_mode, operand_byte, effective_address,
//                instr_length, base_cycles, taken_cycles, stack_first..third
// m_axis    out  write_enable, write_address, write_data, next_pc,
//                status_flags, accumulator, index_x, index_y, stack_pointer,
//                instr_cycles, halted; tlast = last
// cfg       in   index 0 break_target, index 1 start_pc
//
// One instruction per cycle while m_axis is ready; BRK, JSR send one result
// per stack write (3, 2). The back registers results in its output buffer;
// the queue (two entries by default) accepts until full while output stalls.
// Synchronous active-low reset; no clearing pass.
`default_nettype none
module cpu6502_instruction_execute_unit #(
    parameter int QDEPTH = cie_pkg::QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [15:0]               i_cfg_wdata,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // func, accumulator_mode, operand_byte, effective_address, instr_length,
    // base_cycles, taken_cycles, stack_first, stack_second, stack_third
    input  wire logic [cie_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // write_enable, write_address, write_data, next_pc, status_flags,
    // accumulator, index_x, index_y, stack_pointer, instr_cycles, halted
    output logic [cie_pkg::OUT_W-1:0]      o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import cie_pkg::*;

    t_item w_dec, w_head;
    logic  w_full, w_empty, w_pop;

    assign o_s_axis_tready = !w_full;

    cie_front u_front (
        .i_tdata (i_s_axis_tdata),
        .o_item  (w_dec)
    );

    cie_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_item  (w_dec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    cie_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_item      (w_head),
        .o_pop       (w_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
